### rtl/core/ialu_pkg.sv
// Shared types and constants for the integer ALU with power.
package ialu_pkg;

    // Operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5,
        OP_MAX = 3'd6,
        OP_MIN = 3'd7
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_POW,
        ST_FIN,
        ST_OUT
    } t_state;

    // Multiply unit operand select
    typedef enum logic [1:0] {
        MS_AB,
        MS_ACC,
        MS_SQR
    } t_msel;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_start;
        t_msel msel;
        logic div_step;
        logic pow_wacc;
        logic pow_wsqr;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic mul_done;
        logic cnt_last;
        logic exp_bit;
        logic pow_direct;
        logic div_zero;
    } t_sts;

endpackage

### rtl/core/ialu_if.sv
// Valid/ready channel interfaces for requests and results.
interface ialu_req_if #(
    parameter int DW = 64
);
    logic          valid;
    logic          ready;
    logic [2:0]    req_type;
    logic [DW-1:0] operand_a;
    logic [DW-1:0] operand_b;
    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if #(
    parameter int DW = 64
);
    logic          valid;
    logic          ready;
    logic [DW-1:0] result_value;
    logic          divide_error;
    modport source (output valid, result_value, divide_error, input ready);
    modport sink   (input valid, result_value, divide_error, output ready);
endinterface

### rtl/core/integer_alu_with_power.sv
// Top level of the integer ALU with divide and power.
// Usage:
//   req channel (ialu_req_if.sink) carries req_type, operand_a, operand_b.
//   rsp channel (ialu_rsp_if.source) carries result_value and divide_error.
//   One request is processed at a time; req.ready is high only while idle.
// Paths from request accept to result valid:
//   add, sub, max, min, div/mod by zero, pow with negative exponent: load, finish, output.
//   mul: three half-width partial products in the shared multiplier.
//   div, mod: one restoring quotient bit per cycle.
//   pow: each exponent bit costs one
//   square and, when set, one accumulate, each a full multiplier pass.
// The result is held in an output register until rsp.ready takes it; a
// stalled receiver simply holds the block in its output state.
// Reset (synchronous, active low) returns the controller to idle with no
// result pending. Operands narrower than 64 bits use DATA_WIDTH.
module integer_alu_with_power #(
    parameter int DATA_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ialu_req_if.sink   i_req,
    ialu_rsp_if.source o_rsp
);
    ialu_pkg::t_cmd s_cmd;
    ialu_pkg::t_sts s_sts;

    ialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    ialu_dp #(.DW(DATA_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .o_sts      (s_sts),
        .i_req_type (i_req.req_type),
        .i_a        (i_req.operand_a),
        .i_b        (i_req.operand_b),
        .o_result   (o_rsp.result_value),
        .o_err      (o_rsp.divide_error)
    );

    // Requests are only taken while no result is held
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid)) else $error("ready while result held");
    // A taken result returns the block to accepting requests
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> i_req.ready) else $error("not idle");
    // Error flag only for divide or remainder
    a_err_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.divide_error) |-> (s_sts.op == ialu_pkg::OP_DIV ||
        s_sts.op == ialu_pkg::OP_MOD)) else $error("bad divide_error");
endmodule

### rtl/core/ialu_mul.sv
// Multicycle multiplier: half-width (32x32 for DW = 64) partial products, one per cycle, low word kept.
module ialu_mul #(
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_x,
    input  logic [DW-1:0] i_y,
    output logic          o_done,
    output logic [DW-1:0] o_p
);
    localparam int HW = (DW + 1) / 2;

    logic [1:0]    r_step;
    logic          r_busy;
    logic [DW-1:0] r_x, r_y, r_acc;
    logic [DW-1:0] r_pp;
    logic          r_ppv;
    logic [1:0]    r_ppi;
    logic [HW-1:0] s_xa, s_ya;
    logic [2*HW-1:0] s_prod;
    logic [DW-1:0] s_sh;

    // Select halves for this step: lo*lo, lo*hi, hi*lo (hi*hi wraps out)
    always_comb begin
        s_xa = (r_step == 2'd2) ? HW'(r_x[DW-1:HW]) : r_x[HW-1:0];
        s_ya = (r_step == 2'd1) ? HW'(r_y[DW-1:HW]) : r_y[HW-1:0];
    end
    assign s_prod = s_xa * s_ya;

    // Shift registered partial product into place
    assign s_sh = (r_ppi == 2'd0) ? r_pp : (r_pp << HW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_step <= 2'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_ppv  <= 1'b0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_acc  <= '0;
            end else begin
                r_ppv <= r_busy;
                if (r_busy) begin
                    r_pp   <= DW'(s_prod);
                    r_ppi  <= r_step;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) r_busy <= 1'b0;
                end
                if (r_ppv) begin
                    r_acc <= r_acc + s_sh;
                    if (r_ppi == 2'd2) o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = r_acc;
endmodule

### rtl/core/ialu_dp.sv
// Datapath: operand registers, shared multiplier, restoring divider, power loop.
module ialu_dp #(
    parameter int DW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ialu_pkg::t_cmd    i_cmd,
    output ialu_pkg::t_sts    o_sts,
    input  logic [2:0]        i_req_type,
    input  logic [DW-1:0]     i_a,
    input  logic [DW-1:0]     i_b,
    output logic [DW-1:0]     o_result,
    output logic              o_err
);
    localparam int CW = $clog2(DW);

    ialu_pkg::t_op r_op;
    logic [DW-1:0] r_a, r_b;
    logic [DW-1:0] r_q, r_rem, r_dvs;
    logic [DW-1:0] r_acc, r_base, r_exp;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_res;
    logic          r_err;
    logic [DW-1:0] s_mx, s_my, s_mp;
    logic          s_mdone;
    logic [DW:0]   s_trial;
    logic [DW-1:0] s_shr;
    logic          s_na, s_nb, s_alt;

    assign s_na = r_a[DW-1];
    assign s_nb = r_b[DW-1];

    // Multiplier operand selection
    always_comb begin
        case (i_cmd.msel)
            ialu_pkg::MS_AB:  begin s_mx = r_a;   s_my = r_b;   end
            ialu_pkg::MS_ACC: begin s_mx = r_acc; s_my = r_base; end
            ialu_pkg::MS_SQR: begin s_mx = r_base; s_my = r_base; end
            default:          begin s_mx = r_a;   s_my = r_b;   end
        endcase
    end

    ialu_mul #(.DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (s_mx),
        .i_y     (s_my),
        .o_done  (s_mdone),
        .o_p     (s_mp)
    );

    // Restoring division step on magnitudes
    assign s_shr   = {r_rem[DW-2:0], r_q[DW-1]};
    assign s_trial = {1'b0, s_shr} - {1'b0, r_dvs};

    // Power with negative exponent: only base of one or minus one survive
    assign s_alt = (r_a == DW'(1)) || (r_a == '1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= ialu_pkg::t_op'(i_req_type);
            r_a    <= i_a;
            r_b    <= i_b;
            r_q    <= i_a[DW-1] ? (DW'(0) - i_a) : i_a;
            r_dvs  <= i_b[DW-1] ? (DW'(0) - i_b) : i_b;
            r_rem  <= '0;
            r_acc  <= DW'(1);
            r_base <= i_a;
            r_exp  <= i_b;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CW'(1);
            if (!s_trial[DW]) begin
                r_rem <= s_trial[DW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= s_shr;
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
        if (i_cmd.pow_wacc) r_acc <= s_mp;
        if (i_cmd.pow_wsqr) begin
            r_base <= s_mp;
            r_exp  <= r_exp >> 1;
            r_cnt  <= r_cnt + CW'(1);
        end
        // Final result select
        if (i_cmd.finish) begin
            r_err <= 1'b0;
            case (r_op)
                ialu_pkg::OP_ADD: r_res <= r_a + r_b;
                ialu_pkg::OP_SUB: r_res <= r_a - r_b;
                ialu_pkg::OP_MUL: r_res <= s_mp;
                ialu_pkg::OP_DIV: begin
                    r_err <= (r_b == '0);
                    r_res <= (r_b == '0) ? '0 : ((s_na ^ s_nb) ? DW'(0) - r_q : r_q);
                end
                ialu_pkg::OP_MOD: begin
                    r_err <= (r_b == '0);
                    r_res <= (r_b == '0) ? '0 : (s_na ? DW'(0) - r_rem : r_rem);
                end
                ialu_pkg::OP_POW: begin
                    if (s_nb)
                        r_res <= !s_alt ? '0 :
                                 ((r_a == '1 && r_b[0]) ? '1 : DW'(1));
                    else
                        r_res <= r_acc;
                end
                ialu_pkg::OP_MAX: r_res <= ($signed(r_a) < $signed(r_b)) ? r_b : r_a;
                ialu_pkg::OP_MIN: r_res <= ($signed(r_b) < $signed(r_a)) ? r_b : r_a;
                default:          r_res <= r_a;
            endcase
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.mul_done   = s_mdone;
        o_sts.cnt_last   = (r_cnt == CW'(DW - 1));
        o_sts.exp_bit    = r_exp[0];
        o_sts.pow_direct = s_nb;
        o_sts.div_zero   = (r_b == '0);
    end
    assign o_result = r_res;
    assign o_err    = r_err;
endmodule

### rtl/core/ialu_ctrl.sv
// Controller state machine sequencing the datapath for one request at a time.
module ialu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  ialu_pkg::t_sts    i_sts,
    output ialu_pkg::t_cmd    o_cmd
);
    ialu_pkg::t_state r_state, n_state;
    logic r_pend, n_pend;   // multiply in flight, waiting for done
    logic r_sq, n_sq;       // power: 0 = accumulate phase, 1 = square phase

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ialu_pkg::ST_IDLE;
            r_pend  <= 1'b0;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_sq    <= n_sq;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_sq    = r_sq;
        case (r_state)
            ialu_pkg::ST_IDLE: if (i_req_valid) n_state = ialu_pkg::ST_LOAD;
            ialu_pkg::ST_LOAD: begin
                n_pend = 1'b0;
                n_sq   = 1'b0;
                case (i_sts.op)
                    ialu_pkg::OP_MUL: n_state = ialu_pkg::ST_MUL;
                    ialu_pkg::OP_DIV, ialu_pkg::OP_MOD:
                        n_state = i_sts.div_zero ? ialu_pkg::ST_FIN : ialu_pkg::ST_DIV;
                    ialu_pkg::OP_POW:
                        n_state = i_sts.pow_direct ? ialu_pkg::ST_FIN : ialu_pkg::ST_POW;
                    default: n_state = ialu_pkg::ST_FIN;
                endcase
            end
            ialu_pkg::ST_MUL: begin
                n_pend = 1'b1;
                if (r_pend && i_sts.mul_done) n_state = ialu_pkg::ST_FIN;
            end
            ialu_pkg::ST_DIV: if (i_sts.cnt_last) n_state = ialu_pkg::ST_FIN;
            ialu_pkg::ST_POW: begin
                if (!r_pend) begin
                    if (!r_sq && !i_sts.exp_bit) n_sq = 1'b1;
                    else n_pend = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_pend = 1'b0;
                    if (!r_sq) n_sq = 1'b1;
                    else begin
                        n_sq = 1'b0;
                        if (i_sts.cnt_last) n_state = ialu_pkg::ST_FIN;
                    end
                end
            end
            ialu_pkg::ST_FIN: n_state = ialu_pkg::ST_OUT;
            ialu_pkg::ST_OUT: if (i_rsp_ready) n_state = ialu_pkg::ST_IDLE;
            default: n_state = ialu_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.msel      = ialu_pkg::MS_AB;
        o_req_ready     = 1'b0;
        o_rsp_valid     = 1'b0;
        case (r_state)
            ialu_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ialu_pkg::ST_MUL: o_cmd.mul_start = !r_pend;
            ialu_pkg::ST_DIV: o_cmd.div_step  = 1'b1;
            ialu_pkg::ST_POW: begin
                o_cmd.msel = r_sq ? ialu_pkg::MS_SQR : ialu_pkg::MS_ACC;
                if (!r_pend)
                    o_cmd.mul_start = r_sq || i_sts.exp_bit;
                else if (i_sts.mul_done) begin
                    o_cmd.pow_wacc = !r_sq;
                    o_cmd.pow_wsqr = r_sq;
                end
            end
            ialu_pkg::ST_FIN: o_cmd.finish   = 1'b1;
            ialu_pkg::ST_OUT: o_rsp_valid    = 1'b1;
            default: ;
        endcase
    end
endmodule

### tb/sv/integer_alu_with_power_test.sv
// Testbench for the integer ALU with divide and power: predicted results checked in order.
module integer_alu_with_power_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 64;
    localparam int N_RANDOM = 550;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          div_err;
    } t_alu_result;

    // Scoreboard: predicts each accepted request and checks results in order
    class alu_scoreboard;
        t_alu_result pending[$];
        int errors;

        function logic [DW-1:0] raise_pow(logic [DW-1:0] base, logic [DW-1:0] expo);
            logic [DW-1:0] acc;
            acc = DW'(1);
            if (expo[DW-1]) begin
                if (base == DW'(1)) return DW'(1);
                if (base == '1) return expo[0] ? '1 : DW'(1);
                return '0;
            end
            for (int i = 0; i < DW; i++) begin
                if (expo[i]) acc = acc * base;
                base = base * base;
            end
            return acc;
        endfunction

        function void note_request(ialu_pkg::t_op op, logic [DW-1:0] a, logic [DW-1:0] b);
            t_alu_result r;
            logic [DW-1:0] ma, mb, q, m;
            r.value = '0;
            r.div_err = 1'b0;
            case (op)
                ialu_pkg::OP_ADD: r.value = a + b;
                ialu_pkg::OP_SUB: r.value = a - b;
                ialu_pkg::OP_MUL: r.value = a * b;
                ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
                    if (b == '0) begin
                        r.div_err = 1'b1;
                    end else begin
                        ma = a[DW-1] ? -a : a;
                        mb = b[DW-1] ? -b : b;
                        q = ma / mb;
                        m = ma % mb;
                        if (op == ialu_pkg::OP_DIV) r.value = (a[DW-1] != b[DW-1]) ? -q : q;
                        else r.value = a[DW-1] ? -m : m;
                    end
                end
                ialu_pkg::OP_POW: r.value = raise_pow(a, b);
                ialu_pkg::OP_MAX: r.value = ($signed(a) < $signed(b)) ? b : a;
                default: r.value = ($signed(b) < $signed(a)) ? b : a;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [DW-1:0] value, logic div_err);
            t_alu_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h err=%b", $time, value, div_err);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.value !== value) begin
                $display("%0t: result_value expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (e.div_err !== div_err) begin
                $display("%0t: divide_error expected %b actual %b", $time, e.div_err, div_err);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ialu_req_if #(.DW(DW)) req_ch ();
    ialu_rsp_if #(.DW(DW)) rsp_ch ();

    integer_alu_with_power #(.DATA_WIDTH(DW)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    alu_scoreboard sb = new();
    bit stim_done = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    initial begin
        req_ch.valid = 0;
        req_ch.req_type = 0;
        req_ch.operand_a = 0;
        req_ch.operand_b = 0;
        rsp_ch.ready = 0;
    end

    function int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function logic [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = {1'b1, {(DW-1){1'b0}}};
            2: v = {1'b0, {(DW-1){1'b1}}};
            3: v = $urandom_range(0, 1) ? DW'(1) : '1;
            4: v = $signed(DW'($signed($urandom_range(0, 40)) - 20));
            5: v = v >> $urandom_range(0, DW - 1);
            default: ;
        endcase
        return v;
    endfunction

    // Offer one request and hold it until accepted
    task send_request(ialu_pkg::t_op op, logic [DW-1:0] a, logic [DW-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, a, b);
    endtask

    // Directed cases, then random
    initial begin
        logic [DW-1:0] mn, mx, a, b;
        ialu_pkg::t_op op;
        mn = {1'b1, {(DW-1){1'b0}}};
        mx = {1'b0, {(DW-1){1'b1}}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(ialu_pkg::OP_ADD, mx, 1);
        send_request(ialu_pkg::OP_SUB, 5, 0);
        send_request(ialu_pkg::OP_SUB, mn, 1);
        send_request(ialu_pkg::OP_MUL, mx, mx);
        send_request(ialu_pkg::OP_DIV, 7, 0);
        send_request(ialu_pkg::OP_MOD, mn, 0);
        send_request(ialu_pkg::OP_DIV, mn, '1);
        send_request(ialu_pkg::OP_MOD, mn, '1);
        send_request(ialu_pkg::OP_DIV, -7, 2);
        send_request(ialu_pkg::OP_MOD, -7, 2);
        send_request(ialu_pkg::OP_MOD, 7, -2);
        send_request(ialu_pkg::OP_POW, 0, 0);
        send_request(ialu_pkg::OP_POW, 3, 40);
        send_request(ialu_pkg::OP_POW, 1, -5);
        send_request(ialu_pkg::OP_POW, '1, -5);
        send_request(ialu_pkg::OP_POW, '1, -4);
        send_request(ialu_pkg::OP_POW, 0, -1);
        send_request(ialu_pkg::OP_POW, 2, mn);
        send_request(ialu_pkg::OP_MAX, mn, mx);
        send_request(ialu_pkg::OP_MIN, mn, mx);
        send_request(ialu_pkg::OP_MAX, '1, 1);
        send_request(ialu_pkg::OP_MIN, '1, 1);
        for (int i = 0; i < N_RANDOM; i++) begin
            op = ialu_pkg::t_op'($urandom_range(0, 7));
            a = rand_operand();
            b = rand_operand();
            // keep most exponents small so power stays representative
            if (op == ialu_pkg::OP_POW && $urandom_range(0, 3) != 0)
                b = DW'($urandom_range(0, 70));
            if (i == 100) hold_off = 1;
            send_request(op, a, b);
        end
        req_ch.valid <= 0;
        stim_done = 1;
    end

    // Receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                rsp_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.result_value, rsp_ch.divide_error);
        end
    end

    // Watchdog and end of run
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        fork
            begin
                wait (stim_done && sb.pending.size() == 0);
                repeat (50) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                sb.errors++;
            end
        join_any
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
